FILE: rtl/pwm_pkg.sv
// ----------------------------------------------------------------------------
// pwm_pkg
// shared types and constants of the pwm period / duty calculator
// ----------------------------------------------------------------------------
package pwm_pkg;

  localparam int BASE_CLOCK_HZ_DEF = 16000000;
  localparam int COUNTER_SPAN_DEF  = 65536;

  localparam int FREQ_W  = 24;
  localparam int DUTY_W  = 23;
  localparam int CNT_W   = 16;
  localparam int SEL_W   = 2;
  localparam int PROD_W  = CNT_W + DUTY_W;
  localparam int RECIP_W = 24;

  localparam logic [SEL_W-1:0]   SEL_RESET    = 2'd3;
  localparam logic [DUTY_W-1:0]  Q16_ONE      = 23'd65536;
  localparam logic [DUTY_W-1:0]  PCT_LIMIT    = 23'd6553600;
  localparam int                 Q16_SHIFT    = 16;

  // ceil(2^30 / 100), exact divide by 100 for any 23-bit dividend
  localparam logic [RECIP_W-1:0] PCT_RECIP    = 24'd10737419;
  localparam int                 PCT_SHIFT    = 30;

  typedef struct packed {
    logic [FREQ_W-1:0] wanted_frequency;
    logic [DUTY_W-1:0] duty_value;
  } pwm_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] prescaler_minus_one;
    logic [CNT_W-1:0] reload_count;
    logic [CNT_W-1:0] compare_count;
  } pwm_out_t;

endpackage

FILE: rtl/pwm_div_cell.sv
// ----------------------------------------------------------------------------
// pwm_div_cell
// one restoring division step, registered, with side data carried along
// ----------------------------------------------------------------------------
module pwm_div_cell #(
  parameter int W  = 24,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          v_in,
  input  logic [W-1:0]  rem_in,
  input  logic [W-1:0]  dvd_in,
  input  logic [W-1:0]  quo_in,
  input  logic [W-1:0]  den_in,
  input  logic [SW-1:0] side_in,
  output logic          v_r,
  output logic [W-1:0]  rem_r,
  output logic [W-1:0]  dvd_r,
  output logic [W-1:0]  quo_r,
  output logic [W-1:0]  den_r,
  output logic [SW-1:0] side_r
);

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_in, dvd_in[W-1]};
    diff    = trial - {1'b0, den_in};
    ge      = (trial >= {1'b0, den_in});
    rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
    rem_r  <= rem_nxt;
    dvd_r  <= {dvd_in[W-2:0], 1'b0};
    quo_r  <= {quo_in[W-2:0], ge};
    den_r  <= den_in;
    side_r <= side_in;
  end

endmodule

FILE: rtl/pwm_div_chain.sv
// ----------------------------------------------------------------------------
// pwm_div_chain
// row of division cells, one quotient bit per cell, one word per cycle
// ----------------------------------------------------------------------------
module pwm_div_chain #(
  parameter int W  = 24,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          v_in,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  input  logic [SW-1:0] side_in,
  output logic          v_out,
  output logic [W-1:0]  quotient,
  output logic [SW-1:0] side_out
);

  logic          v   [W+1];
  logic [W-1:0]  rem [W+1];
  logic [W-1:0]  dvd [W+1];
  logic [W-1:0]  quo [W+1];
  logic [W-1:0]  den [W+1];
  logic [SW-1:0] sd  [W+1];

  assign v[0]   = v_in;
  assign rem[0] = '0;
  assign dvd[0] = dividend;
  assign quo[0] = '0;
  assign den[0] = divisor;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < W; i++) begin : g_cell
    pwm_div_cell #(.W(W), .SW(SW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_in   (v[i]),
      .rem_in (rem[i]),
      .dvd_in (dvd[i]),
      .quo_in (quo[i]),
      .den_in (den[i]),
      .side_in(sd[i]),
      .v_r    (v[i+1]),
      .rem_r  (rem[i+1]),
      .dvd_r  (dvd[i+1]),
      .quo_r  (quo[i+1]),
      .den_r  (den[i+1]),
      .side_r (sd[i+1])
    );
  end

  assign v_out    = v[W];
  assign quotient = quo[W];
  assign side_out = sd[W];

endmodule

FILE: rtl/pwm_period_duty_calculator.sv
// ----------------------------------------------------------------------------
// pwm_period_duty_calculator
// timer prescaler, auto-reload and compare counts from frequency and duty
// ----------------------------------------------------------------------------
// channel  ports                        direction  meaning
// input    start, busy, in_word         in         frequency and duty word
// result   out_strobe, out_word         out        prescaler, reload, compare
// config   cfg_we, cfg_wdata            in         clock divider select
//
// one word accepted every cycle, busy is always low
// two rows of division cells (ticks, reload) of one quotient bit per
// cell plus one multiply register and one reciprocal register for the
// percent divide by 100
// each result shows on out_strobe for one cycle, receiver cannot stall
// synchronous active-low reset clears the valid bits of every cell
// ----------------------------------------------------------------------------
module pwm_period_duty_calculator #(
  parameter int BASE_CLOCK_HZ = pwm_pkg::BASE_CLOCK_HZ_DEF,
  parameter int COUNTER_SPAN  = pwm_pkg::COUNTER_SPAN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  pwm_pkg::pwm_in_t           in_word,
  output logic                       out_strobe,
  output pwm_pkg::pwm_out_t          out_word,
  input  logic                       cfg_we,
  input  logic [pwm_pkg::SEL_W-1:0]  cfg_wdata
);

  localparam int FW     = pwm_pkg::FREQ_W;
  localparam int DW     = pwm_pkg::DUTY_W;
  localparam int CW     = pwm_pkg::CNT_W;
  localparam int PW     = DW + pwm_pkg::RECIP_W;
  localparam int SPAN_W = $clog2(COUNTER_SPAN);
  localparam logic [FW-1:0] BASE_CLK = FW'(BASE_CLOCK_HZ);

  // config register
  logic [pwm_pkg::SEL_W-1:0] sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= pwm_pkg::SEL_RESET;
    end else if (cfg_we) begin
      sel_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // zero frequency counts as 1 Hz
  logic [FW-1:0] freq_eff;
  logic [FW-1:0] clk_val;

  assign freq_eff = (in_word.wanted_frequency == '0) ? FW'(1) : in_word.wanted_frequency;
  assign clk_val  = BASE_CLK >> sel_r;

  // row 1: ticks = timer clock / frequency
  logic          v1;
  logic [FW-1:0] ticks;
  logic [DW-1:0] duty1;

  pwm_div_chain #(.W(FW), .SW(DW)) u_div_ticks (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_in    (start),
    .dividend(clk_val),
    .divisor (freq_eff),
    .side_in (in_word.duty_value),
    .v_out   (v1),
    .quotient(ticks),
    .side_out(duty1)
  );

  // prescaler is ticks / span + 1, span a power of two
  logic [FW-1:0] psc_m1;
  logic [FW-1:0] psc;

  assign psc_m1 = ticks >> SPAN_W;
  assign psc    = psc_m1 + FW'(1);

  // row 2: reload = ticks / prescaler
  logic          v2;
  logic [FW-1:0] q2;
  logic [DW-1:0] duty2;
  logic [CW-1:0] psc2;

  pwm_div_chain #(.W(FW), .SW(DW + CW)) u_div_reload (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_in    (v1),
    .dividend(ticks),
    .divisor (psc),
    .side_in ({duty1, CW'(psc_m1)}),
    .v_out   (v2),
    .quotient(q2),
    .side_out({duty2, psc2})
  );

  // multiply register, duty class decided here
  logic [CW-1:0]              reload2;
  logic                       is_frac;
  logic                       is_pct;
  logic                       v_m_r;
  logic [pwm_pkg::PROD_W-1:0] prod_r;
  logic [CW-1:0]              psc_m_r;
  logic [CW-1:0]              reload_m_r;
  logic                       frac_m_r;
  logic                       pct_m_r;

  assign reload2 = CW'(q2);
  assign is_frac = (duty2 != '0) && (duty2 < pwm_pkg::Q16_ONE);
  assign is_pct  = (duty2 >= pwm_pkg::Q16_ONE) && (duty2 < pwm_pkg::PCT_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m_r <= 1'b0;
    end else begin
      v_m_r <= v2;
    end
    prod_r     <= pwm_pkg::PROD_W'(reload2) * pwm_pkg::PROD_W'(duty2);
    psc_m_r    <= psc2;
    reload_m_r <= reload2;
    frac_m_r   <= is_frac;
    pct_m_r    <= is_pct;
  end

  // fraction or half-reload answer, ready ahead of the percent stage
  logic [DW-1:0] prod_q16;
  logic [CW-1:0] alt_cmp;

  assign prod_q16 = DW'(prod_r >> pwm_pkg::Q16_SHIFT);
  assign alt_cmp  = frac_m_r ? CW'(prod_q16) : (reload_m_r >> 1);

  // percent compare = (product >> 16) / 100 by reciprocal multiply
  logic          v_d_r;
  logic [PW-1:0] pct_prod_r;
  logic [CW-1:0] psc_d_r;
  logic [CW-1:0] reload_d_r;
  logic [CW-1:0] alt_d_r;
  logic          pct_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d_r <= 1'b0;
    end else begin
      v_d_r <= v_m_r;
    end
    pct_prod_r <= PW'(prod_q16) * PW'(pwm_pkg::PCT_RECIP);
    psc_d_r    <= psc_m_r;
    reload_d_r <= reload_m_r;
    alt_d_r    <= alt_cmp;
    pct_d_r    <= pct_m_r;
  end

  assign out_strobe                   = v_d_r;
  assign out_word.prescaler_minus_one = psc_d_r;
  assign out_word.reload_count        = reload_d_r;
  assign out_word.compare_count       = pct_d_r ? CW'(pct_prod_r >> pwm_pkg::PCT_SHIFT)
                                                : alt_d_r;

`ifndef SYNTHESIS
  // reload always fits the counter
  a_reload_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (32'(out_word.reload_count) < 32'(COUNTER_SPAN)))
    else $error("reload beyond counter span");

  // compare never exceeds reload
  a_cmp_le_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_word.compare_count <= out_word.reload_count))
    else $error("compare above reload");

  // reset empties the cell rows
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result word right after reset");
`endif

endmodule
